// File: hw/rtl/vt4_pkg.sv
// ----------------------------------------------------------------------------
// vt4_pkg
// Shared types and constants for the 4x4 homogeneous vertex transform.
// ----------------------------------------------------------------------------
package vt4_pkg;

  localparam int NUM_COMP      = 4;
  localparam int WORD_W        = 32;
  localparam int PROD_W        = 2 * WORD_W;
  localparam int PAIR_W        = PROD_W + 1;
  localparam int SUM_W         = PROD_W + 2;
  localparam int FRAC_W        = 16;
  localparam int NUM_COEF_REGS = 8;
  localparam int COEF_REG_W    = 64;
  localparam int CFG_IDX_W     = 4;
  localparam int VEC_W         = NUM_COMP * WORD_W;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef word_t                    quad_t [NUM_COMP];
  typedef sum_t                     sum_quad_t [NUM_COMP];

  // identity matrix, two coefficients per register
  localparam logic [COEF_REG_W-1:0] COEF_RESET [NUM_COEF_REGS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  localparam word_t SAT_MAX = 32'sh7FFF_FFFF;
  localparam word_t SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

// File: hw/rtl/vertex_transform_4x4_top.sv
// ----------------------------------------------------------------------------
// vertex_transform_4x4_top
// Row vector times 4x4 matrix in signed Q16.16, saturated to 32 bits.
// ----------------------------------------------------------------------------
// pipeline: 4 register stages (product, pair sum, full sum, clamped result)
// throughput: one vertex per cycle while the output is not stalled, set by the four column lanes working in parallel
// a stalled output register freezes the whole pipeline
// reset clears all valid flags and loads the identity matrix
module vertex_transform_4x4_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [vt4_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vt4_pkg::COEF_REG_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [vt4_pkg::VEC_W-1:0]        in_tdata,  // x_in, y_in, z_in, w_in
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [vt4_pkg::VEC_W-1:0]        out_tdata, // x_out, y_out, z_out, w_out
  output logic                             out_tuser  // saturated
);
  import vt4_pkg::*;

  logic [COEF_REG_W-1:0] coef_r [NUM_COEF_REGS];
  logic [2:0]            vld_r;
  logic [2:0]            vld_nxt;
  logic                  en;
  pipe_ctl_t             mctl;
  quad_t                 vin;
  quad_t                 col [NUM_COMP];
  sum_quad_t             sums;
  quad_t                 comp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RESET;
    end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_COEF_REGS)) begin
      coef_r[cfg_index[2:0]] <= cfg_wdata;
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign vld_nxt   = en ? {vld_r[1:0], in_tvalid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  genvar gi, gj;
  generate
    for (gi = 0; gi < NUM_COMP; gi++) begin : g_in
      assign vin[gi] = in_tdata[gi*WORD_W +: WORD_W];
    end
    for (gj = 0; gj < NUM_COMP; gj++) begin : g_lane
      for (gi = 0; gi < NUM_COMP; gi++) begin : g_coef
        // row gi, column gj: even column in the low word
        assign col[gj][gi] = coef_r[2*gi + gj/2][(gj%2)*WORD_W +: WORD_W];
      end
      vt4_lane u_lane (
        .clk  (clk),
        .en   (en),
        .vin  (vin),
        .coef (col[gj]),
        .sum  (sums[gj])
      );
      assign out_tdata[gj*WORD_W +: WORD_W] = comp[gj];
    end
  endgenerate

  assign mctl.en    = en;
  assign mctl.valid = vld_r[2];

  vt4_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .sums  (sums),
    .comp  (comp),
    .sat   (out_tuser),
    .valid (out_tvalid)
  );

endmodule

// File: hw/rtl/vt4_lane.sv
// ----------------------------------------------------------------------------
// vt4_lane
// One output column: four signed 32x32 products, then a two-level add tree.
// ----------------------------------------------------------------------------
module vt4_lane (
  input  logic          clk,
  input  logic          en,
  input  vt4_pkg::quad_t vin,
  input  vt4_pkg::quad_t coef,
  output vt4_pkg::sum_t  sum
);
  import vt4_pkg::*;

  logic signed [PROD_W-1:0] prod_r [NUM_COMP];
  logic signed [PROD_W-1:0] prod_nxt [NUM_COMP];
  logic signed [PAIR_W-1:0] pair_r [2];
  logic signed [PAIR_W-1:0] pair_nxt [2];
  sum_t                     sum_r;
  sum_t                     sum_nxt;

  always_comb begin
    for (int i = 0; i < NUM_COMP; i++) begin
      prod_nxt[i] = PROD_W'(vin[i]) * PROD_W'(coef[i]);
    end
    pair_nxt[0] = $signed({prod_r[0][PROD_W-1], prod_r[0]})
                + $signed({prod_r[1][PROD_W-1], prod_r[1]});
    pair_nxt[1] = $signed({prod_r[2][PROD_W-1], prod_r[2]})
                + $signed({prod_r[3][PROD_W-1], prod_r[3]});
    // full width sum, four products of 2^62 cannot wrap
    sum_nxt = $signed({pair_r[0][PAIR_W-1], pair_r[0]})
            + $signed({pair_r[1][PAIR_W-1], pair_r[1]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      pair_r <= pair_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

// File: hw/rtl/vt4_merge.sv
// ----------------------------------------------------------------------------
// vt4_merge
// Shifts and clamps the four lane sums and holds the result word.
// ----------------------------------------------------------------------------
module vt4_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  vt4_pkg::pipe_ctl_t ctl,
  input  vt4_pkg::sum_quad_t sums,
  output vt4_pkg::quad_t     comp,
  output logic              sat,
  output logic              valid
);
  import vt4_pkg::*;

  localparam int KEEP_HI = FRAC_W + WORD_W - 1;

  quad_t comp_r;
  quad_t comp_nxt;
  logic  sat_r;
  logic  sat_nxt;
  logic  valid_r;
  logic  valid_nxt;

  always_comb begin
    sat_nxt = 1'b0;
    for (int j = 0; j < NUM_COMP; j++) begin
      // fits when every bit above the kept field matches the sign
      if (sums[j][SUM_W-1:KEEP_HI] == '0 || sums[j][SUM_W-1:KEEP_HI] == '1) begin
        comp_nxt[j] = sums[j][KEEP_HI:FRAC_W];
      end else begin
        comp_nxt[j] = sums[j][SUM_W-1] ? SAT_MIN : SAT_MAX;
        sat_nxt     = 1'b1;
      end
    end
    valid_nxt = ctl.en ? ctl.valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      comp_r <= comp_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign comp  = comp_r;
  assign sat   = sat_r;
  assign valid = valid_r;

endmodule
